/* design/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and the control store of the tap tempo estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned GAP_W    = 16;  // width of a gap that is averaged
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned BPM_W    = 10;
  localparam int unsigned AVG_WINDOW_DEF = 8;

  // Divider: the average pass divides period*(count-1)+gap (21 bits) by count; the tempo pass divides 60000 by period*4
  localparam int unsigned DVD_W    = 21;
  localparam int unsigned DVS_W    = 18;
  localparam int unsigned ITER_W   = 5;

  localparam logic [DVD_W-1:0] TEMPO_NUM = DVD_W'(60000);

  // Register map
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam logic [1:0] REG_RESET_GAP = 2'd0;
  localparam logic [1:0] REG_MIN_BPM   = 2'd1;
  localparam logic [1:0] REG_MAX_BPM   = 2'd2;

  localparam logic [15:0]      RESET_GAP_DEF = 16'd2000;
  localparam logic [BPM_W-1:0] MIN_BPM_DEF   = 10'd20;
  localparam logic [BPM_W-1:0] MAX_BPM_DEF   = 10'd300;

  // Control store
  localparam int unsigned STEP_W = 4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_RESTART,
    OP_LOAD_AVG,
    OP_DIV_STEP,
    OP_SAVE_AVG,
    OP_LOAD_TEMPO,
    OP_CLAMP,
    OP_COMMIT
  } op_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_INPUT,
    JMP_NO_AVG,
    JMP_DIV_BUSY,
    JMP_AVG_ZERO,
    JMP_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_DIV_AVG  = 4'd4;
  localparam logic [STEP_W-1:0] ST_DIV_TMP  = 4'd8;
  localparam logic [STEP_W-1:0] ST_OUT_WAIT = 4'd10;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{op: OP_NOP, cond: JMP_ALWAYS, target: ST_IDLE};
    unique case (step)
      4'd0:  c = '{op: OP_NOP,        cond: JMP_NO_INPUT, target: ST_IDLE};
      4'd1:  c = '{op: OP_RESTART,    cond: JMP_NEVER,    target: ST_IDLE};
      4'd2:  c = '{op: OP_NOP,        cond: JMP_NO_AVG,   target: ST_OUT_WAIT};
      4'd3:  c = '{op: OP_LOAD_AVG,   cond: JMP_NEVER,    target: ST_IDLE};
      4'd4:  c = '{op: OP_DIV_STEP,   cond: JMP_DIV_BUSY, target: ST_DIV_AVG};
      4'd5:  c = '{op: OP_SAVE_AVG,   cond: JMP_NEVER,    target: ST_IDLE};
      4'd6:  c = '{op: OP_NOP,        cond: JMP_AVG_ZERO, target: ST_OUT_WAIT};
      4'd7:  c = '{op: OP_LOAD_TEMPO, cond: JMP_NEVER,    target: ST_IDLE};
      4'd8:  c = '{op: OP_DIV_STEP,   cond: JMP_DIV_BUSY, target: ST_DIV_TMP};
      4'd9:  c = '{op: OP_CLAMP,      cond: JMP_NEVER,    target: ST_IDLE};
      4'd10: c = '{op: OP_NOP,        cond: JMP_OUT_BUSY, target: ST_OUT_WAIT};
      4'd11: c = '{op: OP_COMMIT,     cond: JMP_ALWAYS,   target: ST_IDLE};
      default: c = '{op: OP_NOP,      cond: JMP_ALWAYS,   target: ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

/* design/tap_tempo_estimator.sv */
// ----------------------------------------------------------------------------
// tap_tempo_estimator
// Running-average tap tempo: averages tap gaps and turns the period into BPM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | tap_time_ms_i
//  out     | output    | out_valid_o/out_stall_i | tempo_valid_o, tempo_bpm_o
//  cfg     | input     | APB psel/penable      | reset_gap_ms, min_bpm, max_bpm
//
//  A word with no estimate skips both divider passes, a word whose new average
//  is zero skips the tempo pass, and a word with an estimate runs both passes.
//  The sequencer takes one word at a time; a finished word sits in the output
//  register while the next tap is already taken and worked on.
//  Reset restores the register defaults and clears the tap history.
//  A stalled output holds the sequencer just before it writes the result.
// ----------------------------------------------------------------------------
module tap_tempo_estimator #(
  parameter int unsigned AVG_WINDOW = tte_pkg::AVG_WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tte_pkg::TIME_W-1:0]  tap_time_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        tempo_valid_o,
  output logic [tte_pkg::BPM_W-1:0]   tempo_bpm_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tte_pkg::ADDR_W-1:0]  paddr,
  input  logic [tte_pkg::DATA_W-1:0]  pwdata,
  output logic [tte_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned TW = tte_pkg::TIME_W;
  localparam int unsigned GW = tte_pkg::GAP_W;
  localparam int unsigned CW = tte_pkg::CNT_W;
  localparam int unsigned BW = tte_pkg::BPM_W;
  localparam int unsigned NW = tte_pkg::DVD_W;
  localparam int unsigned DW = tte_pkg::DVS_W;
  localparam int unsigned IW = tte_pkg::ITER_W;
  localparam int unsigned SW = tte_pkg::STEP_W;

  // Configuration registers
  logic [15:0]   reset_gap_q;
  logic [BW-1:0] min_bpm_q, max_bpm_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // Tap state
  logic [TW-1:0] last_tap_q, now_q, gap_q;
  logic [GW-1:0] avg_q;
  logic [CW-1:0] cnt_q;

  // Divider
  logic [NW-1:0] div_n_q;
  logic [DW-1:0] div_d_q, div_r_q;
  logic [IW-1:0] iter_q;
  logic [DW:0]   trial;
  logic          q_bit;

  // Result
  logic          res_valid_q;
  logic [BW-1:0] res_bpm_q;
  logic          out_valid_q, out_tv_q;
  logic [BW-1:0] out_bpm_q;

  // Sequencer
  logic [SW-1:0]   step_q, step_d;
  tte_pkg::ctrl_t  cw;
  logic            jump;
  logic            in_accept, out_busy;
  logic [CW+GW-1:0] weighted;
  logic [BW-1:0]   clamped;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      tte_pkg::REG_RESET_GAP: prdata = {16'd0, reset_gap_q};
      tte_pkg::REG_MIN_BPM:   prdata = {22'd0, min_bpm_q};
      tte_pkg::REG_MAX_BPM:   prdata = {22'd0, max_bpm_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gap_q <= tte_pkg::RESET_GAP_DEF;
      min_bpm_q   <= tte_pkg::MIN_BPM_DEF;
      max_bpm_q   <= tte_pkg::MAX_BPM_DEF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tte_pkg::REG_RESET_GAP: reset_gap_q <= pwdata[15:0];
        tte_pkg::REG_MIN_BPM:   min_bpm_q   <= pwdata[BW-1:0];
        tte_pkg::REG_MAX_BPM:   max_bpm_q   <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  assign cw         = tte_pkg::ucode(step_q);
  assign in_stall_o = (step_q != tte_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;

  always_comb begin
    unique case (cw.cond)
      tte_pkg::JMP_NEVER:    jump = 1'b0;
      tte_pkg::JMP_ALWAYS:   jump = 1'b1;
      tte_pkg::JMP_NO_INPUT: jump = !in_valid_i;
      tte_pkg::JMP_NO_AVG:   jump = (cnt_q == '0) || (gap_q == '0);
      tte_pkg::JMP_DIV_BUSY: jump = (iter_q != IW'(NW - 1));
      tte_pkg::JMP_AVG_ZERO: jump = (avg_q == '0);
      tte_pkg::JMP_OUT_BUSY: jump = out_busy;
      default:               jump = 1'b1;
    endcase
    step_d = jump ? cw.target : step_q + SW'(1);
  end

  // One restoring division step: bring down the next dividend bit
  assign trial = {div_r_q, div_n_q[NW-1]};
  assign q_bit = (trial >= {1'b0, div_d_q});

  assign weighted = avg_q * (cnt_q - CW'(1));

  always_comb begin
    priority if (div_n_q < NW'(min_bpm_q)) clamped = min_bpm_q;
    else if (div_n_q > NW'(max_bpm_q))     clamped = max_bpm_q;
    else                                   clamped = div_n_q[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= tte_pkg::ST_IDLE;
      last_tap_q  <= '0;
      avg_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_bpm_q   <= '0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      step_q <= step_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (cw.op)
        tte_pkg::OP_NOP: begin
          if (in_accept) begin
            res_valid_q <= 1'b0;
            res_bpm_q   <= '0;
          end
        end
        tte_pkg::OP_RESTART: begin
          if (gap_q > TW'(reset_gap_q)) cnt_q <= '0;
        end
        tte_pkg::OP_LOAD_AVG: iter_q <= '0;
        tte_pkg::OP_DIV_STEP: iter_q <= iter_q + IW'(1);
        tte_pkg::OP_SAVE_AVG: avg_q <= div_n_q[GW-1:0];
        tte_pkg::OP_LOAD_TEMPO: iter_q <= '0;
        tte_pkg::OP_CLAMP: begin
          res_valid_q <= 1'b1;
          res_bpm_q   <= clamped;
        end
        tte_pkg::OP_COMMIT: begin
          last_tap_q  <= now_q;
          cnt_q       <= (cnt_q < CW'(AVG_WINDOW)) ? cnt_q + CW'(1) : CW'(AVG_WINDOW);
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= tap_time_ms_i;
      gap_q <= tap_time_ms_i - last_tap_q;
    end
    unique case (cw.op)
      tte_pkg::OP_LOAD_AVG: begin
        // gap is within the reset limit here, so it fits 16 bits
        div_n_q <= NW'(weighted) + NW'(gap_q[GW-1:0]);
        div_d_q <= DW'(cnt_q);
        div_r_q <= '0;
      end
      tte_pkg::OP_LOAD_TEMPO: begin
        div_n_q <= tte_pkg::TEMPO_NUM;
        div_d_q <= {avg_q, 2'b00};
        div_r_q <= '0;
      end
      tte_pkg::OP_DIV_STEP: begin
        div_n_q <= {div_n_q[NW-2:0], q_bit};
        div_r_q <= q_bit ? DW'(trial - {1'b0, div_d_q}) : trial[DW-1:0];
      end
      tte_pkg::OP_COMMIT: begin
        out_tv_q  <= res_valid_q;
        out_bpm_q <= res_bpm_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign tempo_valid_o = out_tv_q;
  assign tempo_bpm_o   = out_bpm_q;

endmodule

/* verif/tap_tempo_estimator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tap_tempo_estimator_test
// Feeds tap timestamps into the estimator with random gaps on the input and
// random back-pressure on the output. A model kept in the bench folds every
// accepted tap into its own running average. Each tempo word is checked in
// order against that model. Phases use different register settings, and the
// registers are written over APB only while the block is drained.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_test;

  localparam int unsigned TIME_W      = tte_pkg::TIME_W;
  localparam int unsigned GAP_W       = tte_pkg::GAP_W;
  localparam int unsigned CNT_W       = tte_pkg::CNT_W;
  localparam int unsigned BPM_W       = tte_pkg::BPM_W;
  localparam int unsigned ADDR_W      = tte_pkg::ADDR_W;
  localparam int unsigned DATA_W      = tte_pkg::DATA_W;
  localparam int unsigned WINDOW      = tte_pkg::AVG_WINDOW_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_TAPS  = 250;

  typedef struct packed {
    logic             valid;
    logic [BPM_W-1:0] bpm;
  } tempo_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              tap_valid  = 1'b0;
  logic              tap_stall;
  logic [TIME_W-1:0] tap_time   = '0;
  logic              word_valid;
  logic              word_stall = 1'b0;
  logic              tempo_valid;
  logic [BPM_W-1:0]  tempo_bpm;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Register shadows and tap history of the bench model
  logic [15:0]       cfg_reset_gap = tte_pkg::RESET_GAP_DEF;
  logic [BPM_W-1:0]  cfg_min_bpm   = tte_pkg::MIN_BPM_DEF;
  logic [BPM_W-1:0]  cfg_max_bpm   = tte_pkg::MAX_BPM_DEF;
  logic [TIME_W-1:0] last_stamp    = '0;
  logic [GAP_W-1:0]  avg_period    = '0;
  logic [CNT_W-1:0]  taps_seen     = '0;

  logic [TIME_W-1:0] tap_queue[$];
  tempo_t            tempo_expect_q[$];
  tempo_t            next_tempo;
  logic [TIME_W-1:0] cursor = '0;
  bit                calm = 1'b0;
  int unsigned       send_idle;
  int unsigned       stall_left;
  int unsigned       quiet_cycles;
  int unsigned       error_count = 0;

  tap_tempo_estimator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (tap_valid),
    .in_stall_o    (tap_stall),
    .tap_time_ms_i (tap_time),
    .out_valid_o   (word_valid),
    .out_stall_i   (word_stall),
    .tempo_valid_o (tempo_valid),
    .tempo_bpm_o   (tempo_bpm),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fold one tap into the running average and return the tempo word it gives
  function automatic tempo_t fold_tap(input logic [TIME_W-1:0] stamp);
    logic [31:0] gap;
    logic [31:0] weighted;
    logic [31:0] raw;
    tempo_t      res;
    res = '0;
    gap = stamp - last_stamp;
    if (gap > 32'(cfg_reset_gap)) taps_seen = '0;
    if (taps_seen != '0 && gap != '0) begin
      weighted = 32'(avg_period) * (32'(taps_seen) - 1) + gap;
      avg_period = GAP_W'(weighted / 32'(taps_seen));
      if (avg_period != '0) begin
        raw = 32'(tte_pkg::TEMPO_NUM) / (32'(avg_period) * 4);
        // with crossed limits a tempo below the lower limit gives it, any other the upper
        if (raw < 32'(cfg_min_bpm)) res.bpm = cfg_min_bpm;
        else if (raw > 32'(cfg_max_bpm)) res.bpm = cfg_max_bpm;
        else res.bpm = BPM_W'(raw);
        res.valid = 1'b1;
      end
    end
    last_stamp = stamp;
    if (taps_seen < CNT_W'(WINDOW)) taps_seen = taps_seen + 1'b1;
    return res;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 200);
  endfunction

  // Step to the next tap: mostly gaps inside the restart limit, some at and
  // just past the limit, some repeats and some wild jumps
  function automatic logic [31:0] pick_step();
    logic [31:0] lim;
    int unsigned r;
    lim = 32'(cfg_reset_gap);
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return lim;
    if (r < 11) return lim + 1;
    if (r < 13) return $urandom;
    if (lim == '0) return '0;
    if (r < 20) return $urandom_range(1, (lim < 8) ? lim : 8);
    if (r < 85) return $urandom_range(1, (lim < 1500) ? lim : 1500);
    return $urandom_range(1, lim);
  endfunction

  function automatic logic [31:0] pick_setting(input logic [31:0] lo_end, hi_end,
                                               typ_lo, typ_hi);
    case ($urandom_range(0, 5))
      0: return lo_end;
      1: return hi_end;
      2: return $urandom_range(lo_end, hi_end);
      default: return $urandom_range(typ_lo, typ_hi);
    endcase
  endfunction

  // Driver: present the next pending tap, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_valid <= 1'b0;
      tap_time  <= '0;
      send_idle <= 0;
    end else if (!tap_valid || !tap_stall) begin
      if (tap_valid) tempo_expect_q.push_back(fold_tap(tap_time));
      if (send_idle != 0) begin
        tap_valid <= 1'b0;
        send_idle <= send_idle - 1;
      end else if (tap_queue.size() != 0) begin
        tap_valid <= 1'b1;
        tap_time  <= tap_queue.pop_front();
        send_idle <= pick_idle();
      end else begin
        tap_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted word against the oldest expected tempo
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (word_valid && !word_stall) begin
        if (tempo_expect_q.size() == 0) begin
          $error("tempo word with no tap pending: tempo_valid %0b tempo_bpm %0d",
                 tempo_valid, tempo_bpm);
          error_count++;
        end else begin
          next_tempo = tempo_expect_q.pop_front();
          if (tempo_valid !== next_tempo.valid) begin
            $error("tempo_valid: expected %0b, got %0b", next_tempo.valid, tempo_valid);
            error_count++;
          end
          if (tempo_bpm !== next_tempo.bpm) begin
            $error("tempo_bpm: expected %0d, got %0d", next_tempo.bpm, tempo_bpm);
            error_count++;
          end
        end
      end
      if (stall_left != 0) begin
        word_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        word_stall <= 1'b1;
        stall_left <= pick_idle();
      end else begin
        word_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((tap_valid && !tap_stall) || (word_valid && !word_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic wait_drained();
    while (tap_queue.size() != 0 || tap_valid || tempo_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Write one register, then read it straight back
  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd_want;
    case (idx)
      tte_pkg::REG_RESET_GAP: rd_want = {16'd0, value[15:0]};
      tte_pkg::REG_MIN_BPM:   rd_want = {22'd0, value[BPM_W-1:0]};
      tte_pkg::REG_MAX_BPM:   rd_want = {22'd0, value[BPM_W-1:0]};
      default:                rd_want = '0;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== rd_want) begin
      $error("prdata: expected %0h, got %0h", rd_want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tte_pkg::REG_RESET_GAP: cfg_reset_gap = value[15:0];
      tte_pkg::REG_MIN_BPM:   cfg_min_bpm   = value[BPM_W-1:0];
      tte_pkg::REG_MAX_BPM:   cfg_max_bpm   = value[BPM_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, then write all three registers; junk in the upper bits is dropped
  task automatic configure(input logic [15:0] gap, input logic [BPM_W-1:0] lo, hi);
    wait_drained();
    repeat (4) @(posedge clk_i);
    apb_write(tte_pkg::REG_RESET_GAP, {16'($urandom), gap});
    apb_write(tte_pkg::REG_MIN_BPM, {22'($urandom), lo});
    apb_write(tte_pkg::REG_MAX_BPM, {22'($urandom), hi});
  endtask

  task automatic tap_at(input logic [TIME_W-1:0] stamp);
    cursor = stamp;
    tap_queue.push_back(stamp);
  endtask

  // Queue bursts of well-formed taps; a burst sometimes opens with a jump
  task automatic queue_taps(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(2, 24);
      if ($urandom_range(0, 3) == 0) cursor = cursor + $urandom;
      repeat (burst) begin
        tap_at(cursor + pick_step());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: first tap measured from zero, repeat, limit, restart, wrap
    tap_at(32'd0);
    tap_at(32'd500);
    tap_at(32'd500);
    tap_at(32'd1000);
    tap_at(32'd1001);
    tap_at(32'd3001);
    tap_at(32'd5002);
    tap_at(32'd5003);
    tap_at(32'hFFFF_FFF0);
    tap_at(32'hFFFF_FFFF);
    tap_at(32'h0000_0009);
    repeat (6) tap_at(cursor + 32'd125);

    // Widest window and limits: very slow taps drop to the lower limit
    configure(16'hFFFF, 10'd1, 10'h3FF);
    tap_at(cursor + 32'd65535);
    tap_at(cursor + 32'd65535);
    tap_at(cursor + 32'd15);

    // All registers zero: any nonzero gap restarts
    configure(16'd0, 10'd0, 10'd0);
    tap_at(cursor);
    tap_at(cursor + 32'd1);
    tap_at(cursor);

    // Lower limit of zero lets a zero tempo through
    configure(16'hFFFF, 10'd0, 10'h3FF);
    tap_at(cursor + 32'd60000);
    tap_at(cursor + 32'd60000);

    // Crossed limits
    configure(16'd3000, 10'd500, 10'd100);
    tap_at(cursor + 32'd100);
    tap_at(cursor + 32'd50);
    tap_at(cursor + 32'd3000);

    for (int p = 0; p < RAND_PHASES; p++) begin
      configure(16'(pick_setting(0, 65535, 100, 3000)),
                BPM_W'(pick_setting(0, 1023, 1, 60)),
                BPM_W'(pick_setting(0, 1023, 150, 400)));
      cursor = $urandom;
      calm = ($urandom_range(0, 3) == 0);
      queue_taps(PHASE_TAPS / 2);
      // hold the sender until every tempo word is back
      wait_drained();
      calm = ($urandom_range(0, 3) == 0);
      queue_taps(PHASE_TAPS / 2);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tte_pkg.sv
design/tap_tempo_estimator.sv
verif/tap_tempo_estimator_test.sv
